// File: rtl/core/pai_pkg.sv
// Shared constants for the piecewise-affine point integrator.
`default_nettype none
package pai_pkg;
  localparam int TABLE_WORDS = 4096;
  localparam int ADDR_W = 12;
  localparam int COORD_W = 24;
  localparam int MAX_CELLS = 16;
  localparam int FRAC_W = 16;
  localparam int ACC_W = 52;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_POINT = 1'b1;

  localparam logic [2:0] REG_DIMENSION = 3'd0;
  localparam logic [2:0] REG_CELLS_X = 3'd1;
  localparam logic [2:0] REG_CELLS_Y = 3'd2;
  localparam logic [2:0] REG_CELLS_Z = 3'd3;
  localparam logic [2:0] REG_STEP_COUNT = 3'd4;
endpackage
`default_nettype wire

// File: rtl/core/piecewise_affine_point_integrator.sv
// Top level: cell lookup and affine stepping over a parameter table memory.
//
//  channel  | ports                                              | handshake
//  request  | command table_address table_value coord_x/y/z      | start & !busy
//  result   | out_x out_y out_z table_overflow                   | result_valid, 1 cycle
//  config   | config_index config_data                           | config_write
//
// A table write does not make the block busy. A point runs step_count steps, with
// ppc of 2, 6 or 12 words per cell: each step does scale, box, cell, base, then
// streams ppc words from the single table read port through one multiplier and updates.
// rst is synchronous; the table itself is not cleared and must be written first.
// The result is shown for one cycle and cannot be held off.
`default_nettype none
module piecewise_affine_point_integrator (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                command,
  input  wire logic [11:0]         table_address,
  input  wire logic signed [23:0]  table_value,
  input  wire logic signed [23:0]  coord_x,
  input  wire logic signed [23:0]  coord_y,
  input  wire logic signed [23:0]  coord_z,
  output logic                     result_valid,
  output logic signed [23:0]       out_x,
  output logic signed [23:0]       out_y,
  output logic signed [23:0]       out_z,
  output logic                     table_overflow,
  input  wire logic                config_write,
  input  wire logic [2:0]          config_index,
  input  wire logic [7:0]          config_data
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_SCALE  = 8'b00000010,
    S_BOX    = 8'b00000100,
    S_CELL   = 8'b00001000,
    S_BASE   = 8'b00010000,
    S_MAC    = 8'b00100000,
    S_UPDATE = 8'b01000000,
    S_OUT    = 8'b10000000
  } state_t;

  localparam logic signed [31:0] ONE = 32'sd65536;

  function automatic logic [3:0] box_of(input logic signed [29:0] s, input logic [4:0] n);
    logic [13:0] hi;
    hi = s[29:16];
    if (s[29]) box_of = '0;
    else if (hi >= {9'd0, n}) box_of = 4'(n - 5'd1);
    else box_of = hi[3:0];
  endfunction

  function automatic logic [16:0] frac_of(input logic signed [29:0] s, input logic [4:0] n);
    logic [13:0] hi;
    hi = s[29:16];
    if (s[29]) frac_of = '0;
    else if (hi >= {9'd0, n}) frac_of = 17'h0FFFF;
    else frac_of = {1'b0, s[15:0]};
  endfunction

  function automatic logic [4:0] eff_cells(input logic [4:0] c);
    if (c == 5'd0) eff_cells = 5'd1;
    else if (c > 5'(pai_pkg::MAX_CELLS)) eff_cells = 5'(pai_pkg::MAX_CELLS);
    else eff_cells = c;
  endfunction

  function automatic logic signed [23:0] sat_round(input logic signed [51:0] v);
    logic signed [51:0] t;
    logic signed [51:0] h;
    t = v + 52'sd32768;
    h = t >>> pai_pkg::FRAC_W;
    if (h > 52'sd8388607) sat_round = 24'sh7FFFFF;
    else if (h < -52'sd8388608) sat_round = 24'sh800000;
    else sat_round = h[23:0];
  endfunction

  state_t state;
  logic [1:0] dim_r;
  logic [4:0] cx_r, cy_r, cz_r;
  logic [7:0] steps_r;
  logic [1:0] d_eff;
  logic [4:0] nx, ny, nz;
  logic [3:0] ppc;

  logic signed [23:0] px, py, pz;
  logic ovf;
  logic [7:0] step_cnt;
  logic signed [29:0] sx, sy, sz;
  logic [3:0] bx, by, bz;
  logic [16:0] fx, fy;
  logic signed [29:0] xr, yr, zr;
  logic [14:0] cell_id;
  logic [11:0] base_q;

  logic [23:0] mem [pai_pkg::TABLE_WORDS];
  logic signed [23:0] rd_data;
  logic [3:0] issue_k;
  logic [1:0] issue_row, issue_col;
  logic v1, v2;
  logic [1:0] r1, c1, r2, c2;
  logic signed [47:0] prod;
  logic signed [51:0] acc;
  logic signed [51:0] row_sum [3];
  logic signed [51:0] acc_sum;
  logic signed [23:0] pc_sel;

  logic [14:0] cell_next;
  logic [19:0] base_full;
  logic [12:0] limit;
  logic accept;

  assign accept = start && !busy;
  assign busy = (state != S_IDLE);
  assign result_valid = (state == S_OUT);
  assign out_x = px;
  assign out_y = py;
  assign out_z = pz;
  assign table_overflow = ovf;

  assign d_eff = (dim_r == 2'd0) ? 2'd1 : dim_r;
  assign nx = eff_cells(cx_r);
  assign ny = eff_cells(cy_r);
  assign nz = eff_cells(cz_r);
  assign ppc = (d_eff == 2'd1) ? 4'd2 : ((d_eff == 2'd2) ? 4'd6 : 4'd12);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dim_r <= 2'd2;
      cx_r <= 5'd4;
      cy_r <= 5'd4;
      cz_r <= 5'd4;
      steps_r <= 8'd8;
    end else if (config_write) begin
      case (config_index)
        pai_pkg::REG_DIMENSION:  dim_r <= config_data[1:0];
        pai_pkg::REG_CELLS_X:    cx_r <= config_data[4:0];
        pai_pkg::REG_CELLS_Y:    cy_r <= config_data[4:0];
        pai_pkg::REG_CELLS_Z:    cz_r <= config_data[4:0];
        pai_pkg::REG_STEP_COUNT: steps_r <= config_data;
        default: ;
      endcase
    end
  end

  // cell index from boxes and fractions
  always_comb begin
    logic [8:0] lin2;
    logic [11:0] lin3;
    logic [1:0] tri_sel;
    logic [2:0] pyr;
    logic signed [31:0] x, y, z, ssx, ssy, nx_one, ny_one;
    lin2 = 9'({5'd0, bx} + 9'(by * nx));
    lin3 = 12'({8'd0, bx} + 12'(by * nx) + 12'(bz * nx * ny));
    x = 32'(xr);
    y = 32'(yr);
    z = 32'(zr);
    ssx = 32'(sx);
    ssy = 32'(sy);
    nx_one = $signed({11'd0, nx, 16'd0});
    ny_one = $signed({11'd0, ny, 16'd0});
    if (px <= 0) begin
      if (py <= 0 && ssy < ssx) tri_sel = 2'd0;
      else if (py >= 24'sd65536 && ssy + ssx > ny_one) tri_sel = 2'd2;
      else tri_sel = 2'd3;
    end else if (px >= 24'sd65536) begin
      if (py <= 0 && ssx + ssy < nx_one) tri_sel = 2'd0;
      else if (py >= 24'sd65536 && ssy + nx_one > ssx + ny_one) tri_sel = 2'd2;
      else tri_sel = 2'd1;
    end else if (py <= 0) begin
      tri_sel = 2'd0;
    end else if (py >= 24'sd65536) begin
      tri_sel = 2'd2;
    end else if (fx < fy) begin
      tri_sel = (fx + fy > 17'h10000) ? 2'd2 : 2'd3;
    end else if (fx + fy > 17'h10000) begin
      tri_sel = 2'd1;
    end else begin
      tri_sel = 2'd0;
    end
    pyr = 3'd0;
    if (x > y && x <= ONE - y && y < z && ONE - y >= z) pyr = pyr + 3'd1;
    if (x >= z && x < ONE - z && y >= z && y < ONE - z) pyr = pyr + 3'd2;
    if (x <= z && x > ONE - z && y <= z && y > ONE - z) pyr = pyr + 3'd3;
    if (x < y && x >= ONE - y && y > z && ONE - y <= z) pyr = pyr + 3'd4;
    if (x >= y && ONE - x < y && x > z && ONE - x <= z) pyr = pyr + 3'd5;
    case (d_eff)
      2'd1:    cell_next = {11'd0, bx};
      2'd2:    cell_next = 15'({lin2, 2'b00}) + 15'(tri_sel);
      default: cell_next = 15'(lin3 * 15'd6) + 15'(pyr);
    endcase
  end

  assign base_full = 20'(cell_id * ppc);
  assign limit = 13'(pai_pkg::TABLE_WORDS) - 13'(ppc);

  always_comb begin
    case (c1)
      2'd0:    pc_sel = px;
      2'd1:    pc_sel = py;
      default: pc_sel = pz;
    endcase
  end

  assign acc_sum = ((c2 == 2'd0) ? 52'sd0 : acc) + 52'(prod);

  // parameter table
  always_ff @(posedge clk) begin
    if (accept && command == pai_pkg::CMD_WRITE) mem[table_address] <= table_value;
    rd_data <= $signed(mem[base_q + 12'(issue_k)]);
  end

  // multiply-accumulate pipeline
  always_ff @(posedge clk) begin
    if (c1 == d_eff) prod <= {{8{rd_data[23]}}, rd_data, 16'd0};
    else prod <= 48'(rd_data * pc_sel);
    r2 <= r1;
    c2 <= c1;
    if (v2) begin
      acc <= acc_sum;
      if (c2 == d_eff) row_sum[r2] <= acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      px <= '0;
      py <= '0;
      pz <= '0;
      ovf <= 1'b0;
      step_cnt <= '0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      issue_k <= '0;
      issue_row <= '0;
      issue_col <= '0;
    end else begin
      v2 <= v1;
      v1 <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && command == pai_pkg::CMD_POINT) begin
            px <= coord_x;
            py <= (d_eff >= 2'd2) ? coord_y : 24'sd0;
            pz <= (d_eff == 2'd3) ? coord_z : 24'sd0;
            ovf <= 1'b0;
            step_cnt <= '0;
            state <= (steps_r == 8'd0) ? S_OUT : S_SCALE;
          end
        end
        S_SCALE: begin
          sx <= 30'(px * $signed({1'b0, nx}));
          sy <= 30'(py * $signed({1'b0, ny}));
          sz <= 30'(pz * $signed({1'b0, nz}));
          state <= S_BOX;
        end
        S_BOX: begin
          bx <= box_of(sx, nx);
          by <= box_of(sy, ny);
          bz <= box_of(sz, nz);
          fx <= frac_of(sx, nx);
          fy <= frac_of(sy, ny);
          xr <= sx - $signed({10'd0, box_of(sx, nx), 16'd0});
          yr <= sy - $signed({10'd0, box_of(sy, ny), 16'd0});
          zr <= sz - $signed({10'd0, box_of(sz, nz), 16'd0});
          state <= S_CELL;
        end
        S_CELL: begin
          cell_id <= cell_next;
          state <= S_BASE;
        end
        S_BASE: begin
          // clamp a cell whose words run past the table end
          if (base_full > {7'd0, limit}) begin
            base_q <= limit[11:0];
            ovf <= 1'b1;
          end else begin
            base_q <= base_full[11:0];
          end
          issue_k <= '0;
          issue_row <= '0;
          issue_col <= '0;
          state <= S_MAC;
        end
        S_MAC: begin
          if (issue_k != ppc) begin
            v1 <= 1'b1;
            r1 <= issue_row;
            c1 <= issue_col;
            issue_k <= issue_k + 4'd1;
            if (issue_col == d_eff) begin
              issue_col <= '0;
              issue_row <= issue_row + 2'd1;
            end else begin
              issue_col <= issue_col + 2'd1;
            end
          end else if (!v1 && !v2) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          px <= sat_round(row_sum[0]);
          py <= (d_eff >= 2'd2) ? sat_round(row_sum[1]) : 24'sd0;
          pz <= (d_eff == 2'd3) ? sat_round(row_sum[2]) : 24'sd0;
          step_cnt <= step_cnt + 8'd1;
          state <= (step_cnt + 8'd1 == steps_r) ? S_OUT : S_SCALE;
        end
        S_OUT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_point_starts: assert property (@(posedge clk) disable iff (rst)
    accept && command == pai_pkg::CMD_POINT |=> busy)
    else $error("point request did not start work");
  a_write_stays_idle: assert property (@(posedge clk) disable iff (rst)
    accept && command == pai_pkg::CMD_WRITE |=> !busy)
    else $error("table write left block busy");
  a_base_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_MAC |-> {1'b0, base_q} <= limit)
    else $error("table base past end");
  a_result_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid && !busy)
    else $error("result held more than one cycle");
`endif

endmodule
`default_nettype wire
